[hdl/evgu_pkg.sv]
// Shared types and constants for the Ethernet/VLAN/IP/GRE/UDP header parser.
package evgu_pkg;

    localparam int MAX_PACKET = 8192;
    localparam int OFF_W      = $clog2(MAX_PACKET + 1);

    localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [15:0] TEB_PROTO   = 16'h6558;
    localparam logic [7:0]  PROTO_GRE   = 8'd47;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [5:0]  IPV4_MIN_HDR = 6'd20;
    localparam logic [3:0]  TUNNEL_MAX  = 4'd15;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_VLAN,
        PH_IPV4,
        PH_IPV6,
        PH_GRE,
        PH_UDP,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        V_UDP     = 3'd0,
        V_TRUNC   = 3'd1,
        V_NOTIP   = 3'd2,
        V_NOTUDP  = 3'd3,
        V_BADGRE  = 3'd4,
        V_BADIHL  = 3'd5
    } verdict_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] udp_source_port;
        logic        inner_is_ipv6;
        logic [13:0] payload_offset;
        logic [13:0] payload_length;
        logic [3:0]  tunnel_count;
    } result_t;

endpackage

[hdl/eth_vlan_ip_gre_udp_header_parser.sv]
// Top level of the streaming Ethernet/VLAN/IPv4/IPv6/GRE/UDP header parser.
//
// Frames enter one byte per transfer on the s_ channel, with s_last_byte marking the final
// byte. The parser walks the Ethernet header, at most one 802.1Q or 802.1ad tag, an IPv4
// header (IHL*4 bytes, IHL below 5 rejected) or the 40-byte IPv6 fixed header, restarts at
// an inner Ethernet header behind GRE carrying transparent Ethernet bridging, and stops
// after the 8-byte UDP header. Exactly one result transfer leaves on the m_ channel per
// frame, formed from the last byte; other bytes give none. Bytes beyond MAX_PACKET (8192)
// are not parsed or counted, though a last byte among them still closes the frame.
// Throughput is one byte per cycle while no closing byte waits: a byte sits in the input
// register while the combinational state update runs, and a frame's result loads into the
// result register at the same edge at which its last byte leaves the input register, so
// m_valid rises once the last byte has passed the input register and the result register.
// Only the last byte of a frame waits on a full result register; ordinary bytes keep
// flowing while a result is held.
module eth_vlan_ip_gre_udp_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [15:0] m_udp_source_port,
    output logic        m_inner_is_ipv6,
    output logic [13:0] m_payload_offset,
    output logic [13:0] m_payload_length,
    output logic [3:0]  m_tunnel_count
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              in_advance;
    logic              out_valid_reg, out_valid_next;
    evgu_pkg::result_t res_reg;
    evgu_pkg::result_t core_result;

    // Advance the input byte unless it closes a frame and the result register is still full
    assign in_advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || in_advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    evgu_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (in_advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (in_advance && in_last_reg) begin
            res_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_verdict         = res_reg.verdict;
    assign m_udp_source_port = res_reg.udp_source_port;
    assign m_inner_is_ipv6   = res_reg.inner_is_ipv6;
    assign m_payload_offset  = res_reg.payload_offset;
    assign m_payload_length  = res_reg.payload_length;
    assign m_tunnel_count    = res_reg.tunnel_count;

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_advance |=> in_valid_reg && $stable(in_data_reg)
        && $stable(in_last_reg))
        else $error("input register overwritten before it advanced");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result raised without a closing byte");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.verdict != evgu_pkg::V_UDP |->
        res_reg.udp_source_port == '0 && res_reg.payload_offset == '0
        && res_reg.payload_length == '0)
        else $error("UDP fields set on a non-UDP verdict");

    a_stall_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && in_valid_reg && in_last_reg |-> !s_ready)
        else $error("closing byte advanced into a full result register");

endmodule

[hdl/evgu_parse_core.sv]
// Per-frame parse state and the single-byte state update of the header walk.
module evgu_parse_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   consume,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output evgu_pkg::result_t      result
);

    evgu_pkg::phase_t             phase_reg, phase_upd, phase_next;
    logic [5:0]                   idx_reg, idx_upd, idx_next;
    logic [evgu_pkg::OFF_W-1:0]   fo_reg, fo_upd, fo_next;
    logic [15:0]                  acc_reg, acc_upd, acc_next;
    logic [5:0]                   ihb_reg, ihb_upd, ihb_next;
    logic [7:0]                   nproto_reg, nproto_upd, nproto_next;
    logic                         v6_reg, v6_upd, v6_next;
    logic [15:0]                  sport_reg, sport_upd, sport_next;
    evgu_pkg::verdict_t           pend_reg, pend_upd, pend_next;
    logic [3:0]                   tun_reg, tun_upd, tun_next;
    logic [evgu_pkg::OFF_W-1:0]   uend_reg, uend_upd, uend_next;
    logic [15:0]                  acc_shift;
    logic [6:0]                   idx_plus1;
    evgu_pkg::verdict_t           verdict;
    logic                         in_window;

    assign acc_shift = {acc_reg[7:0], data_byte};
    assign idx_plus1 = {1'b0, idx_reg} + 7'd1;
    assign in_window = fo_reg < evgu_pkg::OFF_W'(evgu_pkg::MAX_PACKET);

    // Byte update of the header walk
    always_comb begin
        phase_upd  = phase_reg;
        idx_upd    = idx_reg;
        fo_upd     = fo_reg;
        acc_upd    = acc_reg;
        ihb_upd    = ihb_reg;
        nproto_upd = nproto_reg;
        v6_upd     = v6_reg;
        sport_upd  = sport_reg;
        pend_upd   = pend_reg;
        tun_upd    = tun_reg;
        uend_upd   = uend_reg;
        if (in_window) begin
            fo_upd  = fo_reg + evgu_pkg::OFF_W'(1);
            acc_upd = acc_shift;
            idx_upd = idx_plus1[5:0];
            unique case (phase_reg)
                evgu_pkg::PH_ETH, evgu_pkg::PH_VLAN: begin
                    if ((phase_reg == evgu_pkg::PH_ETH && idx_reg == 6'd13) ||
                        (phase_reg == evgu_pkg::PH_VLAN && idx_reg == 6'd3)) begin
                        idx_upd = '0;
                        if (phase_reg == evgu_pkg::PH_ETH &&
                            (acc_shift == evgu_pkg::ETYPE_VLAN ||
                             acc_shift == evgu_pkg::ETYPE_QINQ)) begin
                            phase_upd = evgu_pkg::PH_VLAN;
                        end else if (acc_shift == evgu_pkg::ETYPE_IPV4) begin
                            v6_upd    = 1'b0;
                            phase_upd = evgu_pkg::PH_IPV4;
                        end else if (acc_shift == evgu_pkg::ETYPE_IPV6) begin
                            v6_upd    = 1'b1;
                            phase_upd = evgu_pkg::PH_IPV6;
                        end else begin
                            pend_upd  = evgu_pkg::V_NOTIP;
                            phase_upd = evgu_pkg::PH_DONE;
                        end
                    end
                end
                evgu_pkg::PH_IPV4, evgu_pkg::PH_IPV6: begin
                    if (phase_reg == evgu_pkg::PH_IPV4 && idx_reg == 6'd0) begin
                        ihb_upd = {data_byte[3:0], 2'b00};
                    end
                    if ((phase_reg == evgu_pkg::PH_IPV4 && idx_reg == 6'd9) ||
                        (phase_reg == evgu_pkg::PH_IPV6 && idx_reg == 6'd6)) begin
                        nproto_upd = data_byte;
                    end
                    if (phase_reg == evgu_pkg::PH_IPV4 && idx_reg == 6'd19 &&
                        ihb_reg < evgu_pkg::IPV4_MIN_HDR) begin
                        idx_upd   = '0;
                        pend_upd  = evgu_pkg::V_BADIHL;
                        phase_upd = evgu_pkg::PH_DONE;
                    end else if ((phase_reg == evgu_pkg::PH_IPV4 && idx_reg >= 6'd19 &&
                                  idx_plus1 >= {1'b0, ihb_reg}) ||
                                 (phase_reg == evgu_pkg::PH_IPV6 && idx_reg == 6'd39)) begin
                        idx_upd = '0;
                        if (nproto_reg == evgu_pkg::PROTO_GRE) begin
                            phase_upd = evgu_pkg::PH_GRE;
                        end else if (nproto_reg == evgu_pkg::PROTO_UDP) begin
                            phase_upd = evgu_pkg::PH_UDP;
                        end else begin
                            pend_upd  = evgu_pkg::V_NOTUDP;
                            phase_upd = evgu_pkg::PH_DONE;
                        end
                    end
                end
                evgu_pkg::PH_GRE: begin
                    if (idx_reg == 6'd3) begin
                        idx_upd = '0;
                        if (acc_shift == evgu_pkg::TEB_PROTO) begin
                            if (tun_reg != evgu_pkg::TUNNEL_MAX) begin
                                tun_upd = tun_reg + 4'd1;
                            end
                            phase_upd = evgu_pkg::PH_ETH;
                        end else begin
                            pend_upd  = evgu_pkg::V_BADGRE;
                            phase_upd = evgu_pkg::PH_DONE;
                        end
                    end
                end
                evgu_pkg::PH_UDP: begin
                    if (idx_reg == 6'd1) begin
                        sport_upd = acc_shift;
                    end
                    if (idx_reg == 6'd7) begin
                        idx_upd   = '0;
                        pend_upd  = evgu_pkg::V_UDP;
                        uend_upd  = fo_reg + evgu_pkg::OFF_W'(1);
                        phase_upd = evgu_pkg::PH_PAYLOAD;
                    end
                end
                default: begin
                    // payload and done: hold the index
                    idx_upd = idx_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (phase_upd)
            evgu_pkg::PH_PAYLOAD: verdict = evgu_pkg::V_UDP;
            evgu_pkg::PH_DONE:    verdict = pend_upd;
            default:              verdict = evgu_pkg::V_TRUNC;
        endcase
        result.verdict         = verdict;
        result.inner_is_ipv6   = v6_upd;
        result.tunnel_count    = tun_upd;
        result.udp_source_port = '0;
        result.payload_offset  = '0;
        result.payload_length  = '0;
        if (verdict == evgu_pkg::V_UDP) begin
            result.udp_source_port = sport_upd;
            result.payload_offset  = 14'(uend_upd);
            result.payload_length  = 14'(fo_upd - uend_upd);
        end
    end

    // Apply the update on a consumed byte; restart on the last byte of a frame
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        fo_next     = fo_reg;
        acc_next    = acc_reg;
        ihb_next    = ihb_reg;
        nproto_next = nproto_reg;
        v6_next     = v6_reg;
        sport_next  = sport_reg;
        pend_next   = pend_reg;
        tun_next    = tun_reg;
        uend_next   = uend_reg;
        if (consume) begin
            if (last_byte) begin
                phase_next  = evgu_pkg::PH_ETH;
                idx_next    = '0;
                fo_next     = '0;
                acc_next    = '0;
                ihb_next    = '0;
                nproto_next = '0;
                v6_next     = 1'b0;
                sport_next  = '0;
                pend_next   = evgu_pkg::V_TRUNC;
                tun_next    = '0;
                uend_next   = '0;
            end else begin
                phase_next  = phase_upd;
                idx_next    = idx_upd;
                fo_next     = fo_upd;
                acc_next    = acc_upd;
                ihb_next    = ihb_upd;
                nproto_next = nproto_upd;
                v6_next     = v6_upd;
                sport_next  = sport_upd;
                pend_next   = pend_upd;
                tun_next    = tun_upd;
                uend_next   = uend_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= evgu_pkg::PH_ETH;
            idx_reg    <= '0;
            fo_reg     <= '0;
            acc_reg    <= '0;
            ihb_reg    <= '0;
            nproto_reg <= '0;
            v6_reg     <= 1'b0;
            sport_reg  <= '0;
            pend_reg   <= evgu_pkg::V_TRUNC;
            tun_reg    <= '0;
            uend_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            fo_reg     <= fo_next;
            acc_reg    <= acc_next;
            ihb_reg    <= ihb_next;
            nproto_reg <= nproto_next;
            v6_reg     <= v6_next;
            sport_reg  <= sport_next;
            pend_reg   <= pend_next;
            tun_reg    <= tun_next;
            uend_reg   <= uend_next;
        end
    end

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && last_byte |=> phase_reg == evgu_pkg::PH_ETH && fo_reg == '0)
        else $error("parser did not restart after the last byte");

    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fo_reg <= evgu_pkg::OFF_W'(evgu_pkg::MAX_PACKET))
        else $error("frame offset beyond the packet limit");

    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == evgu_pkg::PH_PAYLOAD || phase_reg == evgu_pkg::PH_DONE)
        |-> idx_reg == '0)
        else $error("header index moved after the walk ended");

endmodule
